// File: rtl/core/ec_host_transaction_sequencer_macros.svh
// assertion macros for the ec host transaction sequencer
// used by the top level only, needs clk_i and rst_ni in scope for the short form

`ifndef EC_HOST_TRANSACTION_SEQUENCER_MACROS_SVH
`define EC_HOST_TRANSACTION_SEQUENCER_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define EC_HTS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// short form on the block clock and reset
`define EC_HTS_ASSERT(lbl, prop, msg) \
  `EC_HTS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/ec_hts_pkg.sv
// types and constants of the ec host transaction sequencer
// no dependencies; used by ec_host_transaction_sequencer, ec_hts_cfg and ec_hts_step
`timescale 1ns / 1ps

package ec_hts_pkg;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // status bits
  localparam int unsigned ST_OBF_BIT = 0;
  localparam int unsigned ST_IBF_BIT = 1;

  // ec commands
  localparam logic [7:0] EC_CMD_READ  = 8'h80;
  localparam logic [7:0] EC_CMD_WRITE = 8'h81;

  // port select
  localparam logic PORT_CMD  = 1'b0;
  localparam logic PORT_DATA = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_POLL_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_MAX_RETRIES  = 2'd1;
  localparam logic [1:0] CFG_SKIP_FAILS   = 2'd2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // configuration reset values
  localparam logic [9:0] POLL_TIMEOUT_RST = 10'd400;
  localparam logic [3:0] MAX_RETRIES_RST  = 4'd10;
  localparam logic [4:0] SKIP_FAILS_RST   = 5'd20;

  localparam logic [4:0] READ_FAIL_MAX = 5'd31;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_RCMD = 3'd1,
    PH_RREG = 3'd2,
    PH_RIBF = 3'd3,
    PH_ROBF = 3'd4,
    PH_WCMD = 3'd5,
    PH_WREG = 3'd6,
    PH_WVAL = 3'd7
  } phase_e;

  typedef struct packed {
    logic [9:0] poll_timeout;
    logic [3:0] max_retries;
    logic [4:0] skip_after_failures;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] reg_addr;
    logic [7:0] write_value;
    logic       word_read;
    logic [7:0] ec_status;
    logic [7:0] ec_data;
  } in_item_t;

  typedef struct packed {
    logic        port_write_valid;
    logic        port_write_target;
    logic [7:0]  port_write_byte;
    logic        data_read_strobe;
    logic        done_res;
    logic [15:0] done_value;
    logic        gave_up;
    logic        ready_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0] current_reg;
    logic [7:0] held_write_byte;
    logic       word_mode;
    logic [9:0] poll_count;
    logic [3:0] retry_count;
    logic [4:0] read_fail_count;
    logic [7:0] first_read;
    logic [7:0] verify_read;
    logic [7:0] low_byte;
    logic [1:0] read_pass;
    logic       high_half;
  } seq_state_t;

endpackage

// File: rtl/core/ec_hts_in_if.sv
// request channel: valid/ready plus one request beat with its status sample
// depends on nothing
`timescale 1ns / 1ps

interface ec_hts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] reg_addr;
  logic [7:0] write_value;
  logic       word_read;
  logic [7:0] ec_status;
  logic [7:0] ec_data;

  modport source (
    output valid, kind, reg_addr, write_value, word_read, ec_status, ec_data,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_addr, write_value, word_read, ec_status, ec_data,
    output ready
  );
endinterface

// File: rtl/core/ec_hts_out_if.sv
// result channel: valid/ready plus one result beat per request beat
// depends on nothing
`timescale 1ns / 1ps

interface ec_hts_out_if;
  logic        valid;
  logic        ready;
  logic        port_write_valid;
  logic        port_write_target;
  logic [7:0]  port_write_byte;
  logic        data_read_strobe;
  logic        done_res;
  logic [15:0] done_value;
  logic        gave_up;
  logic        ready_res;

  modport source (
    output valid, port_write_valid, port_write_target, port_write_byte,
           data_read_strobe, done_res, done_value, gave_up, ready_res,
    input  ready
  );
  modport sink (
    input  valid, port_write_valid, port_write_target, port_write_byte,
           data_read_strobe, done_res, done_value, gave_up, ready_res,
    output ready
  );
endinterface

// File: rtl/core/ec_host_transaction_sequencer.sv
// top level of the ec host transaction sequencer: request register, step logic,
// result register; depends on ec_hts_pkg, ec_hts_in_if, ec_hts_out_if,
// ec_hts_cfg, ec_hts_step and the assertion macro header
//
//   channel   dir  beat                                         handshake
//   req_if    in   kind, reg_addr, write_value, word_read,      valid/ready
//                  ec_status, ec_data
//   res_if    out  port write, read strobe, done, value,        valid/ready
//                  gave_up, ready_res
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_wdata_i             write enable only
//
// one request beat per cycle sustained while res_if.ready is high; each beat goes
// through the request register, then the result register, with the sequencer
// state updated as the step result is registered. a stalled result holds the
// result register; the request register then fills and req_if.ready drops.
// reset clears phase, sequencer state, config (to defaults) and both valid flags.
`timescale 1ns / 1ps
`include "ec_host_transaction_sequencer_macros.svh"

module ec_host_transaction_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ec_hts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ec_hts_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ec_hts_in_if.sink                         req_if,
  ec_hts_out_if.source                      res_if
);

  ec_hts_pkg::cfg_t       cfg;
  ec_hts_pkg::in_item_t   in_item_q, in_item_d;
  ec_hts_pkg::out_item_t  out_item_q, step_res;
  ec_hts_pkg::seq_state_t state_q, state_d;
  ec_hts_pkg::phase_e     phase_q, phase_d;
  logic                   in_valid_q, in_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   advance, req_take;

  ec_hts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ec_hts_step u_step (
    .phase_i (phase_q),
    .state_i (state_q),
    .cfg_i   (cfg),
    .item_i  (in_item_q),
    .phase_o (phase_d),
    .state_o (state_d),
    .res_o   (step_res)
  );

  assign advance       = in_valid_q && (!out_valid_q || res_if.ready);
  assign req_if.ready  = !in_valid_q || advance;
  assign req_take      = req_if.valid && req_if.ready;

  always_comb begin
    in_item_d.kind        = req_if.kind;
    in_item_d.reg_addr    = req_if.reg_addr;
    in_item_d.write_value = req_if.write_value;
    in_item_d.word_read   = req_if.word_read;
    in_item_d.ec_status   = req_if.ec_status;
    in_item_d.ec_data     = req_if.ec_data;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (req_take) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (res_if.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= ec_hts_pkg::PH_IDLE;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q <= phase_d;
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_take) in_item_q <= in_item_d;
    if (advance) out_item_q <= step_res;
  end

  assign res_if.valid             = out_valid_q;
  assign res_if.port_write_valid  = out_item_q.port_write_valid;
  assign res_if.port_write_target = out_item_q.port_write_target;
  assign res_if.port_write_byte   = out_item_q.port_write_byte;
  assign res_if.data_read_strobe  = out_item_q.data_read_strobe;
  assign res_if.done_res          = out_item_q.done_res;
  assign res_if.done_value        = out_item_q.done_value;
  assign res_if.gave_up           = out_item_q.gave_up;
  assign res_if.ready_res         = out_item_q.ready_res;

  `EC_HTS_ASSERT(a_idle_clean, (phase_q == ec_hts_pkg::PH_IDLE) |-> ((state_q.poll_count == '0) && (state_q.retry_count == '0) && (state_q.read_pass == '0) && !state_q.high_half), "idle phase with leftover counters")
  `EC_HTS_ASSERT(a_done_to_idle, (advance && step_res.done_res) |=> (phase_q == ec_hts_pkg::PH_IDLE), "completed request did not return to idle")
  `EC_HTS_ASSERT(a_done_not_idle, (out_valid_q && out_item_q.done_res) |-> !out_item_q.ready_res, "completion reported on an idle beat")

endmodule

// File: rtl/core/ec_hts_cfg.sv
// configuration registers: poll timeout, retry limit, skip threshold
// depends on ec_hts_pkg
`timescale 1ns / 1ps

module ec_hts_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ec_hts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ec_hts_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output ec_hts_pkg::cfg_t                     cfg_o
);

  ec_hts_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ec_hts_pkg::CFG_POLL_TIMEOUT: cfg_d.poll_timeout = cfg_wdata_i[9:0];
        ec_hts_pkg::CFG_MAX_RETRIES:  cfg_d.max_retries = cfg_wdata_i[3:0];
        ec_hts_pkg::CFG_SKIP_FAILS:   cfg_d.skip_after_failures = cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_timeout        <= ec_hts_pkg::POLL_TIMEOUT_RST;
      cfg_q.max_retries         <= ec_hts_pkg::MAX_RETRIES_RST;
      cfg_q.skip_after_failures <= ec_hts_pkg::SKIP_FAILS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ec_hts_step.sv
// one sequencer step: next phase, next state and the result beat for one tick
// depends on ec_hts_pkg; purely combinational
`timescale 1ns / 1ps

module ec_hts_step (
  input  ec_hts_pkg::phase_e     phase_i,
  input  ec_hts_pkg::seq_state_t state_i,
  input  ec_hts_pkg::cfg_t       cfg_i,
  input  ec_hts_pkg::in_item_t   item_i,
  output ec_hts_pkg::phase_e     phase_o,
  output ec_hts_pkg::seq_state_t state_o,
  output ec_hts_pkg::out_item_t  res_o
);

  logic        ibf_clear, obf_set, busy, cond_met, is_req, is_write_ph, skip_obf;
  logic [9:0]  poll_lim;
  logic [3:0]  retry_lim;
  logic        poll_exp, retry_exp, poll_fail, att_fail, gave;
  logic        rbd, rbd_fin, rbd_cont, rbd_finish, wr_finish;
  logic [7:0]  rbd_val;

  assign ibf_clear = !item_i.ec_status[ec_hts_pkg::ST_IBF_BIT];
  assign obf_set   = item_i.ec_status[ec_hts_pkg::ST_OBF_BIT];
  assign busy      = (phase_i != ec_hts_pkg::PH_IDLE);
  assign cond_met  = (phase_i == ec_hts_pkg::PH_ROBF) ? obf_set : ibf_clear;
  assign is_req    = (item_i.kind == ec_hts_pkg::KIND_READ) ||
                     (item_i.kind == ec_hts_pkg::KIND_WRITE);
  assign is_write_ph = (phase_i == ec_hts_pkg::PH_WCMD) ||
                       (phase_i == ec_hts_pkg::PH_WREG) ||
                       (phase_i == ec_hts_pkg::PH_WVAL);
  assign skip_obf  = (state_i.read_fail_count > cfg_i.skip_after_failures);

  // zero limits behave like one
  assign poll_lim  = (cfg_i.poll_timeout == '0) ? 10'd1 : cfg_i.poll_timeout;
  assign retry_lim = (cfg_i.max_retries == '0) ? 4'd1 : cfg_i.max_retries;
  assign poll_exp  = ({1'b0, state_i.poll_count} + 11'd1) >= {1'b0, poll_lim};
  assign retry_exp = ({1'b0, state_i.retry_count} + 5'd1) >= {1'b0, retry_lim};

  assign poll_fail = busy && !cond_met;
  assign att_fail  = poll_fail && poll_exp;
  assign gave      = att_fail && retry_exp;

  // byte read completion, from a data read or from a read that gave up
  assign rbd = ((phase_i == ec_hts_pkg::PH_RIBF) && ibf_clear && skip_obf) ||
               ((phase_i == ec_hts_pkg::PH_ROBF) && obf_set) ||
               (gave && !is_write_ph);
  assign rbd_val    = gave ? 8'h00 : item_i.ec_data;
  assign rbd_fin    = state_i.read_pass[1] ||
                      ((state_i.read_pass == 2'd1) && (state_i.first_read == rbd_val));
  assign rbd_cont   = rbd_fin && !state_i.high_half && state_i.word_mode;
  assign rbd_finish = rbd && rbd_fin && !rbd_cont;
  assign wr_finish  = ((phase_i == ec_hts_pkg::PH_WVAL) && ibf_clear) ||
                      (gave && is_write_ph);

  // next phase
  always_comb begin
    phase_o = phase_i;
    case (phase_i)
      ec_hts_pkg::PH_IDLE: begin
        if (item_i.kind == ec_hts_pkg::KIND_READ) phase_o = ec_hts_pkg::PH_RCMD;
        else if (item_i.kind == ec_hts_pkg::KIND_WRITE) phase_o = ec_hts_pkg::PH_WCMD;
      end
      ec_hts_pkg::PH_RCMD: if (ibf_clear) phase_o = ec_hts_pkg::PH_RREG;
      ec_hts_pkg::PH_WCMD: if (ibf_clear) phase_o = ec_hts_pkg::PH_WREG;
      ec_hts_pkg::PH_RREG: if (ibf_clear) phase_o = ec_hts_pkg::PH_RIBF;
      ec_hts_pkg::PH_WREG: if (ibf_clear) phase_o = ec_hts_pkg::PH_WVAL;
      ec_hts_pkg::PH_RIBF: if (ibf_clear && !skip_obf) phase_o = ec_hts_pkg::PH_ROBF;
      default: ;
    endcase
    if (att_fail && !retry_exp) begin
      phase_o = is_write_ph ? ec_hts_pkg::PH_WCMD : ec_hts_pkg::PH_RCMD;
    end
    if (rbd) begin
      phase_o = rbd_finish ? ec_hts_pkg::PH_IDLE : ec_hts_pkg::PH_RCMD;
    end
    if (wr_finish) begin
      phase_o = ec_hts_pkg::PH_IDLE;
    end
  end

  // state and result beat
  always_comb begin
    state_o = state_i;
    res_o   = '0;
    res_o.ready_res = !busy;
    case (phase_i)
      ec_hts_pkg::PH_IDLE: begin
        if (is_req) begin
          state_o.current_reg     = item_i.reg_addr;
          state_o.held_write_byte = item_i.write_value;
          state_o.word_mode       = (item_i.kind == ec_hts_pkg::KIND_READ) && item_i.word_read;
          state_o.read_pass       = '0;
          state_o.high_half       = 1'b0;
          state_o.retry_count     = '0;
          state_o.poll_count      = '0;
        end
      end
      ec_hts_pkg::PH_RCMD, ec_hts_pkg::PH_WCMD: begin
        if (ibf_clear) begin
          res_o.port_write_valid  = 1'b1;
          res_o.port_write_target = ec_hts_pkg::PORT_CMD;
          res_o.port_write_byte   = (phase_i == ec_hts_pkg::PH_RCMD) ?
                                    ec_hts_pkg::EC_CMD_READ : ec_hts_pkg::EC_CMD_WRITE;
          state_o.poll_count      = '0;
        end
      end
      ec_hts_pkg::PH_RREG, ec_hts_pkg::PH_WREG: begin
        if (ibf_clear) begin
          res_o.port_write_valid  = 1'b1;
          res_o.port_write_target = ec_hts_pkg::PORT_DATA;
          res_o.port_write_byte   = state_i.current_reg;
          state_o.poll_count      = '0;
        end
      end
      ec_hts_pkg::PH_WVAL: begin
        if (ibf_clear) begin
          res_o.port_write_valid  = 1'b1;
          res_o.port_write_target = ec_hts_pkg::PORT_DATA;
          res_o.port_write_byte   = state_i.held_write_byte;
        end
      end
      ec_hts_pkg::PH_RIBF: begin
        if (ibf_clear) begin
          state_o.poll_count     = '0;
          res_o.data_read_strobe = skip_obf;
        end
      end
      ec_hts_pkg::PH_ROBF: begin
        if (obf_set) begin
          state_o.read_fail_count = '0;
          res_o.data_read_strobe  = 1'b1;
        end
      end
      default: ;
    endcase

    // failed poll
    if (poll_fail) begin
      if (!poll_exp) begin
        state_o.poll_count = state_i.poll_count + 10'd1;
      end else begin
        state_o.poll_count = '0;
        if ((phase_i == ec_hts_pkg::PH_ROBF) &&
            (state_i.read_fail_count != ec_hts_pkg::READ_FAIL_MAX)) begin
          state_o.read_fail_count = state_i.read_fail_count + 5'd1;
        end
        if (retry_exp) res_o.gave_up = 1'b1;
        else state_o.retry_count = state_i.retry_count + 4'd1;
      end
    end

    // byte read compare
    if (rbd) begin
      state_o.retry_count = '0;
      state_o.poll_count  = '0;
      if (state_i.read_pass == 2'd0) begin
        state_o.first_read = rbd_val;
        state_o.read_pass  = 2'd1;
      end else if (state_i.read_pass == 2'd1) begin
        state_o.verify_read = rbd_val;
        if (!rbd_fin) state_o.read_pass = 2'd2;
      end
      if (rbd_fin) state_o.read_pass = '0;
      if (rbd_cont) begin
        state_o.low_byte    = rbd_val;
        state_o.high_half   = 1'b1;
        state_o.current_reg = state_i.current_reg + 8'd1;
      end
      if (rbd_finish) begin
        res_o.done_res   = 1'b1;
        res_o.done_value = state_i.high_half ? {rbd_val, state_i.low_byte}
                                             : {8'h00, rbd_val};
      end
    end

    if (rbd_finish || wr_finish) begin
      state_o.poll_count  = '0;
      state_o.retry_count = '0;
      state_o.read_pass   = '0;
      state_o.high_half   = 1'b0;
    end
    if (wr_finish) begin
      res_o.done_res = 1'b1;
    end
  end

endmodule

// File: verif/tb_top.sv
// self-checking bench for ec_host_transaction_sequencer: drives request beats with status
// samples, predicts every result beat in a scoreboard class and compares field by field
// depends on ec_hts_pkg, ec_hts_in_if, ec_hts_out_if and the block itself
`timescale 1ns / 1ps

module tb_top;
  import ec_hts_pkg::*;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int RUN_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;

  class ec_seq_scoreboard;
    logic [9:0] poll_timeout;
    logic [3:0] max_retries;
    logic [4:0] skip_fails;
    phase_e     phase;
    logic [7:0] cur_reg, held_byte, first_rd, verify_rd, low_byte;
    logic       word_mode, high_half;
    logic [9:0] poll_cnt;
    logic [3:0] retry_cnt;
    logic [4:0] rd_fail_cnt;
    logic [1:0] rd_pass;
    out_item_t  expected_steps[$];
    int errors, n_beats, n_done, n_gave_up, n_skip, n_third;

    function new();
      poll_timeout = POLL_TIMEOUT_RST;
      max_retries = MAX_RETRIES_RST;
      skip_fails = SKIP_FAILS_RST;
      phase = PH_IDLE;
      cur_reg = '0; held_byte = '0; first_rd = '0; verify_rd = '0; low_byte = '0;
      word_mode = 1'b0; high_half = 1'b0;
      poll_cnt = '0; retry_cnt = '0; rd_fail_cnt = '0; rd_pass = '0;
      errors = 0; n_beats = 0; n_done = 0; n_gave_up = 0; n_skip = 0; n_third = 0;
    endfunction

    function void set_regs(logic [9:0] t, logic [3:0] r, logic [4:0] s);
      poll_timeout = t;
      max_retries = r;
      skip_fails = s;
    endfunction

    function void drive_port(inout out_item_t o, input logic tgt, input logic [7:0] b);
      o.port_write_valid = 1'b1;
      o.port_write_target = tgt;
      o.port_write_byte = b;
    endfunction

    function void close_request(inout out_item_t o, input logic [15:0] v);
      o.done_res = 1'b1;
      o.done_value = v;
      phase = PH_IDLE;
      poll_cnt = '0;
      retry_cnt = '0;
      rd_pass = '0;
      high_half = 1'b0;
      n_done++;
    endfunction

    function void restart_byte();
      retry_cnt = '0;
      poll_cnt = '0;
      phase = PH_RCMD;
    endfunction

    // two reads per byte, a third one decides when they differ
    function void byte_read_done(inout out_item_t o, input logic [7:0] v);
      logic [7:0] r;
      bit fin;
      r = '0;
      fin = 1'b0;
      if (rd_pass == 2'd0) begin
        first_rd = v;
        rd_pass = 2'd1;
      end else if (rd_pass == 2'd1) begin
        verify_rd = v;
        if (first_rd == v) begin
          r = v;
          fin = 1'b1;
        end else begin
          rd_pass = 2'd2;
        end
      end else begin
        r = v;
        fin = 1'b1;
        n_third++;
      end
      if (!fin) begin
        restart_byte();
        return;
      end
      rd_pass = '0;
      if (!high_half && word_mode) begin
        low_byte = r;
        high_half = 1'b1;
        cur_reg = cur_reg + 8'd1;
        restart_byte();
      end else begin
        close_request(o, high_half ? {r, low_byte} : {8'h00, r});
      end
    endfunction

    function void poll_failed(inout out_item_t o, input bit is_write, input bit obf_wait);
      int lim_poll, lim_try;
      lim_poll = (poll_timeout == 0) ? 1 : int'(poll_timeout);
      lim_try = (max_retries == 0) ? 1 : int'(max_retries);
      if (int'(poll_cnt) + 1 < lim_poll) begin
        poll_cnt = poll_cnt + 10'd1;
        return;
      end
      if (obf_wait && rd_fail_cnt < READ_FAIL_MAX) rd_fail_cnt = rd_fail_cnt + 5'd1;
      poll_cnt = '0;
      if (int'(retry_cnt) + 1 >= lim_try) begin
        o.gave_up = 1'b1;
        n_gave_up++;
        if (is_write) close_request(o, 16'h0000);
        else byte_read_done(o, 8'h00);
      end else begin
        retry_cnt = retry_cnt + 4'd1;
        phase = is_write ? PH_WCMD : PH_RCMD;
      end
    endfunction

    function out_item_t step_sequencer(in_item_t it);
      out_item_t o;
      bit ibf_clr, obf_set;
      o = '0;
      ibf_clr = !it.ec_status[ST_IBF_BIT];
      obf_set = it.ec_status[ST_OBF_BIT];
      o.ready_res = (phase == PH_IDLE);
      case (phase)
        PH_IDLE: begin
          if (it.kind == KIND_READ || it.kind == KIND_WRITE) begin
            cur_reg = it.reg_addr;
            held_byte = it.write_value;
            word_mode = (it.kind == KIND_READ) ? it.word_read : 1'b0;
            rd_pass = '0;
            high_half = 1'b0;
            retry_cnt = '0;
            poll_cnt = '0;
            phase = (it.kind == KIND_READ) ? PH_RCMD : PH_WCMD;
          end
        end
        PH_RCMD, PH_WCMD: begin
          if (ibf_clr) begin
            drive_port(o, PORT_CMD, (phase == PH_RCMD) ? EC_CMD_READ : EC_CMD_WRITE);
            poll_cnt = '0;
            phase = (phase == PH_RCMD) ? PH_RREG : PH_WREG;
          end else begin
            poll_failed(o, phase == PH_WCMD, 1'b0);
          end
        end
        PH_RREG, PH_WREG: begin
          if (ibf_clr) begin
            drive_port(o, PORT_DATA, cur_reg);
            poll_cnt = '0;
            phase = (phase == PH_RREG) ? PH_RIBF : PH_WVAL;
          end else begin
            poll_failed(o, phase == PH_WREG, 1'b0);
          end
        end
        PH_WVAL: begin
          if (ibf_clr) begin
            drive_port(o, PORT_DATA, held_byte);
            close_request(o, 16'h0000);
          end else begin
            poll_failed(o, 1'b1, 1'b0);
          end
        end
        PH_RIBF: begin
          if (ibf_clr) begin
            poll_cnt = '0;
            // too many failed output-full waits: read data right away
            if (rd_fail_cnt > skip_fails) begin
              o.data_read_strobe = 1'b1;
              n_skip++;
              byte_read_done(o, it.ec_data);
            end else begin
              phase = PH_ROBF;
            end
          end else begin
            poll_failed(o, 1'b0, 1'b0);
          end
        end
        PH_ROBF: begin
          if (obf_set) begin
            rd_fail_cnt = '0;
            o.data_read_strobe = 1'b1;
            byte_read_done(o, it.ec_data);
          end else begin
            poll_failed(o, 1'b0, 1'b1);
          end
        end
        default: phase = PH_IDLE;
      endcase
      return o;
    endfunction

    function void note_request_beat(in_item_t it);
      expected_steps.push_back(step_sequencer(it));
      n_beats++;
    endfunction

    function void report_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t %s: expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_result_beat(out_item_t got);
      out_item_t want;
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, got %h", $time, got);
        return;
      end
      want = expected_steps.pop_front();
      report_field("port_write_valid", 16'(want.port_write_valid),
                   16'(got.port_write_valid));
      report_field("port_write_target", 16'(want.port_write_target),
                   16'(got.port_write_target));
      report_field("port_write_byte", 16'(want.port_write_byte),
                   16'(got.port_write_byte));
      report_field("data_read_strobe", 16'(want.data_read_strobe),
                   16'(got.data_read_strobe));
      report_field("done_res", 16'(want.done_res), 16'(got.done_res));
      report_field("done_value", want.done_value, got.done_value);
      report_field("gave_up", 16'(want.gave_up), 16'(got.gave_up));
      report_field("ready_res", 16'(want.ready_res), 16'(got.ready_res));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ec_hts_in_if  req_if ();
  ec_hts_out_if res_if ();

  ec_host_transaction_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_if      (req_if),
    .res_if      (res_if)
  );

  ec_seq_scoreboard sb = new();

  bit         src_idle_on;
  bit         sink_idle_on;
  bit         hold_off_req;
  logic [7:0] stream_data;
  int         cycle_count;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= RUN_LIMIT);
    $display("timeout after %0d cycles", RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // status sample steered toward the condition the sequencer waits on
  function automatic in_item_t make_tick(int ibf_bad, int obf_bad, int mism);
    in_item_t it;
    it.kind = ($urandom_range(0, 99) < 85) ? KIND_TICK : 2'($urandom_range(0, 3));
    if (sb.phase == PH_IDLE) it.kind = $urandom_range(0, 1) ? KIND_TICK : KIND_SPARE;
    it.reg_addr = 8'($urandom);
    it.write_value = 8'($urandom);
    it.word_read = 1'($urandom);
    it.ec_data = ($urandom_range(0, 99) < mism) ? 8'($urandom) : stream_data;
    it.ec_status = 8'($urandom);
    case (sb.phase)
      PH_IDLE: ;
      PH_ROBF: it.ec_status[ST_OBF_BIT] = ($urandom_range(0, 99) >= obf_bad);
      default: it.ec_status[ST_IBF_BIT] = ($urandom_range(0, 99) < ibf_bad);
    endcase
    return it;
  endfunction

  task automatic put_beat(in_item_t it);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= it.kind;
    req_if.reg_addr <= it.reg_addr;
    req_if.write_value <= it.write_value;
    req_if.word_read <= it.word_read;
    req_if.ec_status <= it.ec_status;
    req_if.ec_data <= it.ec_data;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.note_request_beat(it);
  endtask

  task automatic run_request(logic [1:0] kind, logic [7:0] addr, logic [7:0] val,
                             logic word, int ibf_bad, int obf_bad, int mism);
    in_item_t it;
    bit was_high;
    stream_data = 8'($urandom);
    it = make_tick(ibf_bad, obf_bad, mism);
    it.kind = kind;
    it.reg_addr = addr;
    it.write_value = val;
    it.word_read = word;
    put_beat(it);
    was_high = 1'b0;
    while (sb.phase != PH_IDLE) begin
      if (sb.high_half && !was_high) begin
        was_high = 1'b1;
        stream_data = 8'($urandom);
      end
      put_beat(make_tick(ibf_bad, obf_bad, mism));
    end
  endtask

  task automatic program_regs(logic [9:0] t, logic [3:0] r, logic [4:0] s);
    req_if.valid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_POLL_TIMEOUT;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_RETRIES;
    cfg_wdata_i <= CFG_DATA_W'(r);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SKIP_FAILS;
    cfg_wdata_i <= CFG_DATA_W'(s);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_regs(t, r, s);
  endtask

  task automatic run_phase(logic [9:0] t, logic [3:0] r, logic [4:0] s, int ibf_bad,
                           int obf_bad, int mism, bit idle, int beats);
    int start;
    logic [7:0] addr;
    program_regs(t, r, s);
    src_idle_on = idle;
    sink_idle_on = idle ? 1'b1 : 1'($urandom);
    start = sb.n_beats;
    while (sb.n_beats - start < beats) begin
      if ($urandom_range(0, 9) == 0) begin
        put_beat(make_tick(ibf_bad, obf_bad, mism));
      end else begin
        addr = ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom);
        run_request($urandom_range(0, 2) ? KIND_READ : KIND_WRITE, addr, 8'($urandom),
                    1'($urandom), ibf_bad, obf_bad, mism);
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    out_item_t got;
    res_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = sink_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
      got.port_write_valid = res_if.port_write_valid;
      got.port_write_target = res_if.port_write_target;
      got.port_write_byte = res_if.port_write_byte;
      got.data_read_strobe = res_if.data_read_strobe;
      got.done_res = res_if.done_res;
      got.done_value = res_if.done_value;
      got.gave_up = res_if.gave_up;
      got.ready_res = res_if.ready_res;
      sb.check_result_beat(got);
    end
  end

  initial begin : stimulus
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    hold_off_req = 1'b0;
    stream_data = '0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.kind <= KIND_TICK;
    req_if.reg_addr <= '0;
    req_if.write_value <= '0;
    req_if.word_read <= 1'b0;
    req_if.ec_status <= '0;
    req_if.ec_data <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, clean handshakes
    run_request(KIND_READ, 8'h00, 8'h00, 1'b0, 0, 0, 0);
    run_request(KIND_READ, 8'hFF, 8'hFF, 1'b1, 0, 0, 0);
    run_request(KIND_WRITE, 8'h00, 8'hFF, 1'b1, 0, 0, 0);
    run_request(KIND_WRITE, 8'hFF, 8'h00, 1'b0, 0, 0, 0);
    run_request(KIND_READ, 8'h5A, 8'h00, 1'b0, 0, 0, 100);
    put_beat(make_tick(0, 0, 0));
    // directed: single-poll timeout, single attempt, give-ups and skipped wait
    program_regs(10'd1, 4'd1, 5'd0);
    run_request(KIND_WRITE, 8'h11, 8'h22, 1'b0, 100, 0, 0);
    run_request(KIND_READ, 8'h33, 8'h00, 1'b0, 0, 100, 0);
    run_request(KIND_READ, 8'h44, 8'h00, 1'b1, 0, 0, 0);

    // random: extremes first, then drawn settings, saturation of the fail count last
    hold_off_req = 1'b1;
    run_phase(10'd1023, 4'd15, 5'd30, 15, 15, 20, 1'b1, 90);
    run_phase(10'd0, 4'd0, 5'd0, 40, 50, 25, 1'b0, 70);
    run_phase(10'd1, 4'd1, 5'd0, 30, 60, 30, 1'b1, 70);
    run_phase(10'd3, 4'd2, 5'd5, 30, 40, 25, 1'b1, 70);
    repeat (4) begin
      run_phase(10'($urandom_range(1, 8)), 4'($urandom_range(1, 4)),
                5'($urandom_range(0, 6)), $urandom_range(0, 40), $urandom_range(0, 50),
                $urandom_range(0, 40), 1'($urandom), 60);
    end
    run_phase(10'd1, 4'd1, 5'd30, 5, 100, 30, 1'b1, 100);

    req_if.valid <= 1'b0;
    while (sb.expected_steps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("run covered %0d request beats, %0d finished requests, %0d give-ups",
             sb.n_beats, sb.n_done, sb.n_gave_up);
    $display("%0d reads past a skipped output-full wait, %0d third reads, fail count %0d",
             sb.n_skip, sb.n_third, sb.rd_fail_cnt);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
